[design/tdbfb_pkg.sv]
package tdbfb_pkg;

  // Default geometry of the tile window and of the screen it moves across.
  localparam int TDBFB_TILE_W   = 32;
  localparam int TDBFB_TILE_H   = 32;
  localparam int TDBFB_SCREEN_W = 160;
  localparam int TDBFB_SCREEN_H = 128;
  localparam int TDBFB_ROW_BITS = 16;

  localparam int PIXEL_W = 16;
  localparam int COORD_W = 16;
  localparam int GWIDTH_W = 5;
  localparam int RIDX_W = 10;
  localparam int TILE_POS_W = 8;

  // APB register map: one 32-bit register per word.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_FOREGROUND = 1'b0;

  typedef enum logic [1:0] {
    ACT_PUT_PIXEL   = 2'd0,
    ACT_DRAW_ROW    = 2'd1,
    ACT_SWAP        = 2'd2,
    ACT_READ_ACTIVE = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SWAP,
    ST_DONE
  } state_e;

  typedef struct packed {
    action_e               action;
    logic [COORD_W-1:0]    pos_x;
    logic [COORD_W-1:0]    pos_y;
    logic [PIXEL_W-1:0]    pixel_colour;
    logic [PIXEL_W-1:0]    glyph_bits;
    logic [GWIDTH_W-1:0]   glyph_width;
    logic [RIDX_W-1:0]     read_index;
  } item_t;

  typedef struct packed {
    logic [PIXEL_W-1:0]    read_pixel;
    logic [TILE_POS_W-1:0] sent_tile_x;
    logic [TILE_POS_W-1:0] sent_tile_y;
    logic                  frame_wrapped;
  } result_t;

endpackage

[design/tdbfb_stream_if.sv]
interface tdbfb_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[design/tdbfb_ram.sv]
module tdbfb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/tiled_double_buffered_framebuffer_core.sv]
// Items are handled one at a time: put_pixel writes one pixel, draw_row walks its glyph row
// one pixel per cycle, read_active reads the active bank, and swap sweeps the new shadow bank.
// A new item is accepted as soon as the previous one has left its result in the output register,
// so items never overlap; the single write port of the pixel memory is why draw_row and the
// swap sweep write one entry at a time. Reset (rst_ni low, asynchronous) clears the control
// registers and then starts a clearing pass over both banks, during which no item is taken.
module tiled_double_buffered_framebuffer_core
  import tdbfb_pkg::*;
#(
  parameter int TILE_W   = TDBFB_TILE_W,
  parameter int TILE_H   = TDBFB_TILE_H,
  parameter int SCREEN_W = TDBFB_SCREEN_W,
  parameter int SCREEN_H = TDBFB_SCREEN_H,
  parameter int ROW_BITS = TDBFB_ROW_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tdbfb_stream_if.sink          item_i,
  tdbfb_stream_if.source        result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Both banks live in one memory: bank b starts at entry b*BANK_SIZE.
  localparam int BANK_SIZE = TILE_W * TILE_H;
  localparam int DEPTH     = 2 * BANK_SIZE;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int DX_W      = (TILE_W > 1) ? $clog2(TILE_W) : 1;
  localparam int DY_W      = (TILE_H > 1) ? $clog2(TILE_H) : 1;
  localparam int XW        = COORD_W + 1;
  localparam int NW        = TILE_POS_W + 1;
  localparam logic [ADDR_W-1:0] BANK_BASE = ADDR_W'(BANK_SIZE);
  localparam logic [ADDR_W-1:0] BANK_LAST = ADDR_W'(BANK_SIZE - 1);
  localparam logic [ADDR_W-1:0] MEM_LAST  = ADDR_W'(DEPTH - 1);

  state_e state_q, state_d;

  item_t                  item_q, item_d;
  logic [GWIDTH_W-1:0]    col_q, col_d;
  logic [GWIDTH_W-1:0]    gw_q, gw_d;
  logic [PIXEL_W-1:0]     glyph_q, glyph_d;
  logic                   active_sel_q, active_sel_d;
  logic [TILE_POS_W-1:0]  left_q, left_d;
  logic [TILE_POS_W-1:0]  top_q, top_d;
  logic [PIXEL_W-1:0]     fg_q, fg_d;
  result_t                res_q, res_d;
  result_t                out_q, out_d;
  logic                   out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]      clr_addr_q, clr_addr_d;
  logic [ADDR_W-1:0]      clr_last_q, clr_last_d;
  logic                   clr_to_done_q, clr_to_done_d;

  logic                   ram_we, ram_re;
  logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
  logic [PIXEL_W-1:0]     ram_wdata, ram_rdata;

  logic                   item_take;
  logic                   out_free;
  logic                   cfg_write;

  // Pixel address generation for put_pixel and draw_row.
  logic [XW-1:0]          pix_x, pix_y;
  logic                   in_window;
  logic [DX_W-1:0]        dx;
  logic [DY_W-1:0]        dy;
  logic [ADDR_W-1:0]      shadow_base, active_base, pix_addr;
  logic                   draw_bit;
  logic                   exec_last;
  logic                   read_ok;
  logic [NW-1:0]          next_left, next_top;

  // ---------------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; reads are
  // combinational.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_FOREGROUND);
  assign prdata    = (paddr[2] == REG_FOREGROUND) ? CFG_DATA_W'(fg_q) : '0;
  assign fg_d      = cfg_write ? pwdata[PIXEL_W-1:0] : fg_q;

  // ---------------------------------------------------------------------------
  // Handshakes. An item is only taken in the idle state. The output register is a
  // separate stage: the next item can run while a result is unclaimed, but then waits in ST_DONE.
  // ---------------------------------------------------------------------------
  assign item_i.ready     = (state_q == ST_IDLE);
  assign item_take        = item_i.valid && item_i.ready;
  assign out_free         = !out_valid_q || result_o.ready;
  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;

  // ---------------------------------------------------------------------------
  // Window clipping and bank addressing. The compare is done without wrap,
  // one bit wider than the coordinates.
  // ---------------------------------------------------------------------------
  assign shadow_base = active_sel_q ? '0 : BANK_BASE;
  assign active_base = active_sel_q ? BANK_BASE : '0;

  assign pix_x = XW'(item_q.pos_x) + XW'(col_q);
  assign pix_y = XW'(item_q.pos_y);

  assign in_window = (pix_x >= XW'(left_q)) &&
                     (pix_x <= XW'(left_q) + XW'(TILE_W - 1)) &&
                     (pix_y >= XW'(top_q)) &&
                     (pix_y <= XW'(top_q) + XW'(TILE_H - 1));

  assign dx       = DX_W'(pix_x - XW'(left_q));
  assign dy       = DY_W'(pix_y - XW'(top_q));
  assign pix_addr = shadow_base + ADDR_W'(dy) * ADDR_W'(TILE_W) + ADDR_W'(dx);

  // Glyph bits are walked MSB first through a shift register.
  assign draw_bit  = glyph_q[PIXEL_W-1];
  assign exec_last = (item_q.action == ACT_PUT_PIXEL) || (gw_q == '0) ||
                     (col_q == gw_q - GWIDTH_W'(1));

  assign read_ok = (32'(item_q.read_index) < BANK_SIZE);

  // Window step on swap: one tile right, or to the next tile row, or home.
  assign next_left = NW'(left_q) + NW'(TILE_W);
  assign next_top  = NW'(top_q) + NW'(TILE_H);

  // ---------------------------------------------------------------------------
  // Next-state logic.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == clr_last_q) begin
          state_d = clr_to_done_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_take) begin
          case (item_i.payload.action)
            ACT_SWAP: state_d = ST_SWAP;
            default:  state_d = ST_EXEC;
          endcase
        end
      end
      ST_EXEC: begin
        if (item_q.action == ACT_READ_ACTIVE) begin
          state_d = ST_READ;
        end else if (exec_last) begin
          state_d = ST_DONE;
        end
      end
      ST_READ:  state_d = ST_DONE;
      ST_SWAP:  state_d = ST_CLEAR;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and memory control per state.
  // ---------------------------------------------------------------------------
  always_comb begin
    item_d        = item_q;
    col_d         = col_q;
    gw_d          = gw_q;
    glyph_d       = glyph_q;
    active_sel_d  = active_sel_q;
    left_d        = left_q;
    top_d         = top_q;
    res_d         = res_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && !result_o.ready;
    clr_addr_d    = clr_addr_q;
    clr_last_d    = clr_last_q;
    clr_to_done_d = clr_to_done_q;
    ram_we        = 1'b0;
    ram_waddr     = pix_addr;
    ram_wdata     = fg_q;
    ram_re        = 1'b0;
    ram_raddr     = active_base + ADDR_W'(item_q.read_index);

    case (state_q)
      ST_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        ram_wdata  = '0;
        clr_addr_d = clr_addr_q + ADDR_W'(1);
      end
      ST_IDLE: begin
        if (item_take) begin
          item_d  = item_i.payload;
          col_d   = '0;
          glyph_d = item_i.payload.glyph_bits;
          gw_d    = (32'(item_i.payload.glyph_width) > ROW_BITS) ?
                    GWIDTH_W'(ROW_BITS) : item_i.payload.glyph_width;
          res_d   = '0;
        end
      end
      ST_EXEC: begin
        case (item_q.action)
          ACT_PUT_PIXEL: begin
            ram_we    = in_window;
            ram_wdata = item_q.pixel_colour;
          end
          ACT_DRAW_ROW: begin
            ram_we  = in_window && draw_bit && (gw_q != '0);
            col_d   = col_q + GWIDTH_W'(1);
            glyph_d = {glyph_q[PIXEL_W-2:0], 1'b0};
          end
          ACT_READ_ACTIVE: begin
            ram_re = read_ok;
          end
          default: begin
          end
        endcase
      end
      ST_READ: begin
        res_d.read_pixel = read_ok ? ram_rdata : '0;
      end
      ST_SWAP: begin
        res_d.sent_tile_x = left_q;
        res_d.sent_tile_y = top_q;
        active_sel_d      = !active_sel_q;
        if (next_left >= NW'(SCREEN_W)) begin
          left_d = '0;
          if (next_top >= NW'(SCREEN_H)) begin
            top_d               = '0;
            res_d.frame_wrapped = 1'b1;
          end else begin
            top_d = next_top[TILE_POS_W-1:0];
          end
        end else begin
          left_d = next_left[TILE_POS_W-1:0];
        end
        // The old active bank becomes the shadow bank and is swept clean.
        clr_addr_d    = active_base;
        clr_last_d    = active_base + BANK_LAST;
        clr_to_done_d = 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers. Control state is reset; payload registers are not.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      active_sel_q  <= 1'b0;
      left_q        <= '0;
      top_q         <= '0;
      fg_q          <= '0;
      out_valid_q   <= 1'b0;
      clr_addr_q    <= '0;
      clr_last_q    <= MEM_LAST;
      clr_to_done_q <= 1'b0;
      col_q         <= '0;
      gw_q          <= '0;
    end else begin
      state_q       <= state_d;
      active_sel_q  <= active_sel_d;
      left_q        <= left_d;
      top_q         <= top_d;
      fg_q          <= fg_d;
      out_valid_q   <= out_valid_d;
      clr_addr_q    <= clr_addr_d;
      clr_last_q    <= clr_last_d;
      clr_to_done_q <= clr_to_done_d;
      col_q         <= col_d;
      gw_q          <= gw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    glyph_q <= glyph_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  tdbfb_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (DEPTH)
  ) u_pixel_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTHESIS
  // A swap always hands over to the clearing sweep with the window on screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWAP) |=> (state_q == ST_CLEAR) && (32'(left_q) < SCREEN_W))
    else $error("swap did not start the shadow clear or left the screen");

  // The sweep after a swap must stay inside the new shadow bank.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && clr_to_done_q) |->
      (ram_waddr >= shadow_base) && (ram_waddr <= shadow_base + BANK_LAST))
    else $error("clear sweep wrote outside the shadow bank");

  // Drawing writes land only in the shadow bank.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && ram_we) |->
      (ram_waddr >= shadow_base) && (ram_waddr <= shadow_base + BANK_LAST))
    else $error("pixel write outside the shadow bank");

  // A finished result waits while the output register is still occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && !result_o.ready) |=>
      (state_q == ST_DONE) && out_valid_q)
    else $error("result overwrote an unclaimed output");
`endif

endmodule

[dv/tb_tiled_double_buffered_framebuffer_core.sv]
module tb_tiled_double_buffered_framebuffer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tdbfb_pkg::*;

  // Geometry of the instance under test, which keeps the package defaults.
  localparam int TILE_W      = TDBFB_TILE_W;
  localparam int TILE_H      = TDBFB_TILE_H;
  localparam int SCREEN_W    = TDBFB_SCREEN_W;
  localparam int SCREEN_H    = TDBFB_SCREEN_H;
  localparam int ROW_BITS    = TDBFB_ROW_BITS;
  localparam int BANK_PIXELS = TILE_W * TILE_H;

  // Drawing and reading favor the top-left corner of the tile, so that reads of the
  // active bank often land on pixels that were actually drawn.
  localparam int HOT_SPAN = 8;

  // Chance, in percent, that either side sits out a cycle while gaps are enabled.
  localparam int GAP_PCT = 9;

  // The longest legal stretch without any transfer is the clearing pass after reset, which
  // sweeps both banks; a swap sweeps only one. This limit is several times longer.
  localparam int STALL_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  tdbfb_stream_if #(.payload_t(item_t))   item_if ();
  tdbfb_stream_if #(.payload_t(result_t)) result_if ();

  tiled_double_buffered_framebuffer_core u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Shadow copy of the framebuffer state. It advances when an item is accepted, so the
  // expected result of every item is known long before the block produces it.
  // ---------------------------------------------------------------------------------------
  logic [PIXEL_W-1:0]    bank_copy [2][BANK_PIXELS];
  logic                  active_sel;
  logic [TILE_POS_W-1:0] win_left;
  logic [TILE_POS_W-1:0] win_top;
  logic [PIXEL_W-1:0]    fg_colour;

  // Results still owed by the block, oldest first.
  result_t pending_results[$];

  bit          gaps_on;
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned swaps_done;
  int unsigned wraps_seen;
  int unsigned reg_writes;
  int unsigned stall_cycles = 0;

  result_t seen_result;
  result_t owed_result;

  initial begin
    foreach (bank_copy[b, i]) bank_copy[b][i] = '0;
    active_sel = 1'b0;
    win_left   = '0;
    win_top    = '0;
    fg_colour  = '0;
  end

  // A pixel is kept only when it falls inside the current window; the bounds are
  // evaluated in 32 bits so that coordinates near the top of the 16-bit range never wrap.
  function automatic void plot_shadow(int unsigned x, int unsigned y,
                                      logic [PIXEL_W-1:0] colour);
    int unsigned l;
    int unsigned t;
    l = win_left;
    t = win_top;
    if (x >= l && x <= l + TILE_W - 1 && y >= t && y <= t + TILE_H - 1) begin
      bank_copy[~active_sel][(y - t) * TILE_W + (x - l)] = colour;
    end
  endfunction

  function automatic result_t framebuffer_response(item_t it);
    result_t     res;
    int unsigned span;
    int unsigned next_left;
    int unsigned next_top;
    res = '0;
    case (it.action)
      ACT_PUT_PIXEL: begin
        plot_shadow(it.pos_x, it.pos_y, it.pixel_colour);
      end
      ACT_DRAW_ROW: begin
        // Widths beyond the glyph row saturate; bit 15 is the leftmost column.
        span = (it.glyph_width > ROW_BITS) ? ROW_BITS : it.glyph_width;
        for (int col = 0; col < span; col++) begin
          if (it.glyph_bits[PIXEL_W-1-col]) begin
            plot_shadow(int'(it.pos_x) + col, it.pos_y, fg_colour);
          end
        end
      end
      ACT_SWAP: begin
        res.sent_tile_x = win_left;
        res.sent_tile_y = win_top;
        active_sel = ~active_sel;
        next_left  = int'(win_left) + TILE_W;
        next_top   = win_top;
        if (next_left >= SCREEN_W) begin
          next_left = 0;
          next_top  = next_top + TILE_H;
          if (next_top >= SCREEN_H) begin
            next_top          = 0;
            res.frame_wrapped = 1'b1;
            wraps_seen++;
          end
        end
        win_left = TILE_POS_W'(next_left);
        win_top  = TILE_POS_W'(next_top);
        for (int i = 0; i < BANK_PIXELS; i++) bank_copy[~active_sel][i] = '0;
        swaps_done++;
      end
      ACT_READ_ACTIVE: begin
        if (it.read_index < BANK_PIXELS) res.read_pixel = bank_copy[active_sel][it.read_index];
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------------------
  function automatic item_t make_item(action_e act, int unsigned x, int unsigned y,
                                      int unsigned colour, int unsigned bits,
                                      int unsigned width, int unsigned index);
    item_t it;
    it.action       = act;
    it.pos_x        = COORD_W'(x);
    it.pos_y        = COORD_W'(y);
    it.pixel_colour = PIXEL_W'(colour);
    it.glyph_bits   = PIXEL_W'(bits);
    it.glyph_width  = GWIDTH_W'(width);
    it.read_index   = RIDX_W'(index);
    return it;
  endfunction

  function automatic action_e pick_action();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 38) return ACT_PUT_PIXEL;
    if (roll < 62) return ACT_DRAW_ROW;
    if (roll < 91) return ACT_READ_ACTIVE;
    return ACT_SWAP;
  endfunction

  // Fields that the action ignores still carry random values. Drawing is mostly aimed into
  // the current window, with some coordinates just outside it and some anywhere at all.
  function automatic item_t random_item(action_e act);
    item_t       it;
    int unsigned roll;
    int unsigned reach;
    it = make_item(act, $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom_range(16, 0), $urandom());
    if ($urandom_range(99, 0) < 15) it.glyph_width = GWIDTH_W'($urandom_range(31, 17));
    if ($urandom_range(1, 0) == 1) begin
      it.read_index = RIDX_W'($urandom_range(HOT_SPAN - 1, 0) * TILE_W +
                              $urandom_range(HOT_SPAN - 1, 0));
    end
    if (act == ACT_PUT_PIXEL || act == ACT_DRAW_ROW) begin
      roll = $urandom_range(99, 0);
      if (roll >= 25) begin
        reach    = ($urandom_range(1, 0) == 1) ? HOT_SPAN : TILE_W;
        it.pos_x = COORD_W'(int'(win_left) + $urandom_range(reach - 1, 0));
        it.pos_y = COORD_W'(int'(win_top) + $urandom_range(reach - 1, 0));
        // Glyph rows often start left of the pixels they should reach, or run off the
        // right edge, so both clipping sides are exercised.
        if (act == ACT_DRAW_ROW) it.pos_x = it.pos_x - COORD_W'($urandom_range(7, 0));
      end else if (roll >= 15) begin
        it.pos_x = ($urandom_range(1, 0) == 1) ? COORD_W'(int'(win_left) - 1)
                                               : COORD_W'(int'(win_left) + TILE_W);
        it.pos_y = COORD_W'(int'(win_top) - 1 + $urandom_range(TILE_H + 1, 0));
        if ($urandom_range(1, 0) == 1) begin
          {it.pos_x, it.pos_y} = {it.pos_y - COORD_W'(win_top) + COORD_W'(win_left),
                                  it.pos_x - COORD_W'(win_left) + COORD_W'(win_top)};
        end
      end
    end
    return it;
  endfunction

  // Presents one item and waits for its transfer. Valid stays high afterwards so that a
  // following item can go out back to back; wait_drained lowers it.
  task automatic send_item(item_t it);
    while (gaps_on && $urandom_range(99, 0) < GAP_PCT) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid   <= 1'b1;
    item_if.payload <= it;
    do @(posedge clk_i); while (!item_if.ready);
    pending_results.push_back(framebuffer_response(it));
    items_sent++;
  endtask

  task automatic wait_drained();
    item_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes the foreground colour, then reads it back. The upper data bits are random,
  // since only the low 16 bits belong to the register.
  task automatic write_foreground(logic [PIXEL_W-1:0] colour);
    logic [CFG_DATA_W-1:0] word;
    word    = {16'($urandom()), colour};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(int'(REG_FOREGROUND) * 4);
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    fg_colour = word[PIXEL_W-1:0];
    reg_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[PIXEL_W-1:0] !== fg_colour) begin
      $error("foreground_colour: expected 0x%04h, got 0x%04h", fg_colour, prdata[PIXEL_W-1:0]);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------------------
  // Result side: random backpressure and an in-order comparison against the expectations.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (result_if.valid && result_if.ready) begin
      seen_result = result_if.payload;
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: 0x%h", seen_result);
        fail_count++;
      end else begin
        owed_result = pending_results.pop_front();
        results_checked++;
        if (seen_result.read_pixel !== owed_result.read_pixel) begin
          $error("read_pixel: expected 0x%04h, got 0x%04h",
                 owed_result.read_pixel, seen_result.read_pixel);
          fail_count++;
        end
        if (seen_result.sent_tile_x !== owed_result.sent_tile_x) begin
          $error("sent_tile_x: expected %0d, got %0d",
                 owed_result.sent_tile_x, seen_result.sent_tile_x);
          fail_count++;
        end
        if (seen_result.sent_tile_y !== owed_result.sent_tile_y) begin
          $error("sent_tile_y: expected %0d, got %0d",
                 owed_result.sent_tile_y, seen_result.sent_tile_y);
          fail_count++;
        end
        if (seen_result.frame_wrapped !== owed_result.frame_wrapped) begin
          $error("frame_wrapped: expected %0b, got %0b",
                 owed_result.frame_wrapped, seen_result.frame_wrapped);
          fail_count++;
        end
      end
    end
    result_if.ready <= !(gaps_on && $urandom_range(99, 0) < GAP_PCT);
  end

  // The watchdog counts cycles without any transfer on the item, result or register port.
  always @(posedge clk_i) begin
    if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready) ||
        (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Timeout: no transfer for %0d cycles, %0d results outstanding.",
             STALL_LIMIT, pending_results.size());
    $display("** tiled_double_buffered_framebuffer_core: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------------------

  // The register takes an ordinary value and both extremes, ending on all ones so that the
  // directed glyph rows draw in a colour that cannot be mistaken for cleared memory.
  task automatic test_register_access();
    write_foreground(16'hA5A5);
    write_foreground(16'h0000);
    write_foreground(16'hFFFF);
  endtask

  // Runs right after reset, with the window at the origin and both banks clear.
  task automatic test_directed_cases();
    // Empty active bank reads as zero, both at the first and the last index.
    send_item(make_item(ACT_READ_ACTIVE, 0, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_READ_ACTIVE, 0, 0, 0, 0, 0, BANK_PIXELS - 1));
    // Corners of the window are kept; one step past either edge, or the largest
    // coordinates, are clipped away.
    send_item(make_item(ACT_PUT_PIXEL, 0, 0, 16'hFFFF, 0, 0, 0));
    send_item(make_item(ACT_PUT_PIXEL, TILE_W - 1, TILE_H - 1, 16'h0001, 0, 0, 0));
    send_item(make_item(ACT_PUT_PIXEL, TILE_W, 0, 16'h1234, 0, 0, 0));
    send_item(make_item(ACT_PUT_PIXEL, 0, TILE_H, 16'h4321, 0, 0, 0));
    send_item(make_item(ACT_PUT_PIXEL, 16'hFFFF, 16'hFFFF, 16'hBEEF, 0, 0, 0));
    // A full glyph row that runs off the right edge, an oversized width, a zero width,
    // an all-clear bitmap, and a row starting at the top of the coordinate range.
    send_item(make_item(ACT_DRAW_ROW, TILE_W - 8, 1, 0, 16'hFFFF, ROW_BITS, 0));
    send_item(make_item(ACT_DRAW_ROW, 0, 2, 0, 16'h8001, 31, 0));
    send_item(make_item(ACT_DRAW_ROW, 0, 3, 0, 16'hFFFF, 0, 0));
    send_item(make_item(ACT_DRAW_ROW, 0, 4, 0, 16'h0000, ROW_BITS, 0));
    send_item(make_item(ACT_DRAW_ROW, 16'hFFFF, 5, 0, 16'hFFFF, ROW_BITS, 0));
    // Drawing touched only the shadow bank.
    send_item(make_item(ACT_READ_ACTIVE, 0, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_SWAP, 0, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_READ_ACTIVE, 0, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_READ_ACTIVE, 0, 0, 0, 0, 0, BANK_PIXELS - 1));
    send_item(make_item(ACT_READ_ACTIVE, 0, 0, 0, 0, 0, TILE_W + TILE_W - 1));
    send_item(make_item(ACT_READ_ACTIVE, 0, 0, 0, 0, 0, 2 * TILE_W + ROW_BITS - 1));
    send_item(make_item(ACT_READ_ACTIVE, 0, 0, 0, 0, 0, 3 * TILE_W));
    // The second swap brings back the bank that was cleared by the first one.
    send_item(make_item(ACT_SWAP, 0, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_READ_ACTIVE, 0, 0, 0, 0, 0, 0));
    wait_drained();
  endtask

  // Walks the window over every tile of the screen and one more, so the wrap back to
  // the origin is always seen, marking each tile's corners and checking them after the swap.
  task automatic test_frame_sweep();
    for (int n = 0; n < (SCREEN_W / TILE_W) * (SCREEN_H / TILE_H) + 1; n++) begin
      send_item(make_item(ACT_PUT_PIXEL, win_left, win_top, $urandom(), 0, 0, 0));
      send_item(make_item(ACT_PUT_PIXEL, int'(win_left) + TILE_W - 1,
                          int'(win_top) + TILE_H - 1, $urandom(), 0, 0, 0));
      send_item(make_item(ACT_DRAW_ROW, int'(win_left) + TILE_W - 8, int'(win_top) + 1,
                          0, $urandom(), ROW_BITS, 0));
      send_item(make_item(ACT_SWAP, 0, 0, 0, 0, 0, 0));
      send_item(make_item(ACT_READ_ACTIVE, 0, 0, 0, 0, 0, 0));
      send_item(make_item(ACT_READ_ACTIVE, 0, 0, 0, 0, 0, BANK_PIXELS - 1));
    end
    wait_drained();
  endtask

  // Random traffic in phases; the foreground colour changes between phases while idle.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 9; phase++) begin
      wait_drained();
      case (phase)
        0:       write_foreground(16'h0000);
        1:       write_foreground(16'hFFFF);
        default: write_foreground(16'($urandom()));
      endcase
      for (int n = 0; n < 150; n++) send_item(random_item(pick_action()));
    end
    wait_drained();
  endtask

  // A stretch with both sides always ready, so items and results move at full rate.
  task automatic test_back_to_back();
    gaps_on = 1'b0;
    write_foreground(16'($urandom()));
    for (int n = 0; n < 250; n++) send_item(random_item(pick_action()));
    wait_drained();
    gaps_on = 1'b1;
  endtask

  initial begin
    fail_count      = 0;
    items_sent      = 0;
    results_checked = 0;
    swaps_done      = 0;
    wraps_seen      = 0;
    reg_writes      = 0;
    gaps_on         = 1'b1;

    rst_ni            <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    item_if.valid     <= 1'b0;
    item_if.payload   <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_access();
    test_directed_cases();
    test_frame_sweep();
    test_random_traffic();
    test_back_to_back();

    // Anything the block still sends after this point has no expectation and fails.
    wait_drained();
    repeat (50) @(posedge clk_i);

    $display("Sent %0d items and checked %0d results, with %0d swaps and %0d screen wraps.",
             items_sent, results_checked, swaps_done, wraps_seen);
    $display("The foreground register was written and read back %0d times.", reg_writes);
    if (fail_count == 0) begin
      $display("** tiled_double_buffered_framebuffer_core: PASSED **");
    end else begin
      $display("** tiled_double_buffered_framebuffer_core: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
design/tdbfb_pkg.sv
design/tdbfb_stream_if.sv
design/tdbfb_ram.sv
design/tiled_double_buffered_framebuffer_core.sv
dv/tb_tiled_double_buffered_framebuffer_core.sv
